FILE: hw/rtl/ckhm_pkg.sv
package ckhm_pkg;

    // Node store size: one cell per node
    localparam int NODE_CAPACITY = 256;

    // Field widths
    localparam int KEY_W    = 28;
    localparam int PIDX_W   = 8;
    localparam int STATUS_W = 2;

    // Operation codes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_INSERT = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL = 2'd2;

    // Item travelling down the cell chain
    typedef struct packed {
        logic              valid;
        logic              op;
        logic [KEY_W-1:0]  key;
        logic [PIDX_W-1:0] pidx;
        logic              hit;      // key matched in an earlier cell
        logic              claimed;  // insert already took a free cell
        logic [PIDX_W-1:0] idx;      // palette index of the matching node
    } t_item;

endpackage

FILE: hw/rtl/color_key_hash_map.sv
// Color key map: packed 28-bit color key -> 8-bit palette index.
// Input channel: i_valid / o_stall with i_op (0 lookup, 1 insert), i_color_key,
// i_palette_index. A transfer happens on a clock edge with i_valid high and
// o_stall low.
// Output channel: o_valid / i_stall with o_found, o_stored_index, o_status
// (0 ok, 1 duplicate insert, 2 table full). One result per input transfer,
// in input order.
// Each stored node lives in one cell of a chain of NODE_CAPACITY cells. An item
// moves one cell per cycle unless the chain is frozen: it is compared to the node
// there, and an insert that has met no match takes the first empty cell it reaches.
// Each result passes through the stage register of every cell and then the
// output register before o_valid rises.
// Throughput: one item per cycle while not frozen, set by the one-cell-per-cycle
// advance of the chain; later items see nodes stored by earlier inserts.
// Reset (i_rst_n low, synchronous) empties every cell and the chain; the
// block takes input in the first cycle after reset.
// When i_stall holds a waiting result, the whole chain freezes and o_stall
// rises until the result is taken.
module color_key_hash_map (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_op,
    input  logic [ckhm_pkg::KEY_W-1:0]    i_color_key,
    input  logic [ckhm_pkg::PIDX_W-1:0]   i_palette_index,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_found,
    output logic [ckhm_pkg::PIDX_W-1:0]   o_stored_index,
    output logic [ckhm_pkg::STATUS_W-1:0] o_status
);

    ckhm_pkg::t_item                        w_item [ckhm_pkg::NODE_CAPACITY+1];
    logic [ckhm_pkg::NODE_CAPACITY-1:0]     w_node_valid;
    logic                                   w_adv;

    // Chain advances unless a finished result is held by the receiver
    assign w_adv   = !(o_valid && i_stall);
    assign o_stall = !w_adv;

    // Item entering the first cell
    always_comb begin
        w_item[0]         = '0;
        w_item[0].valid   = i_valid && w_adv;
        w_item[0].op      = i_op;
        w_item[0].key     = i_color_key;
        w_item[0].pidx    = i_palette_index;
        w_item[0].hit     = 1'b0;
        w_item[0].claimed = 1'b0;
        w_item[0].idx     = '0;
    end

    // Row of node cells
    for (genvar k = 0; k < ckhm_pkg::NODE_CAPACITY; k++) begin : g_cell
        ckhm_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_adv        (w_adv),
            .i_item       (w_item[k]),
            .o_item       (w_item[k+1]),
            .o_node_valid (w_node_valid[k])
        );
    end

    ckhm_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_adv          (w_adv),
        .i_item         (w_item[ckhm_pkg::NODE_CAPACITY]),
        .o_valid        (o_valid),
        .o_found        (o_found),
        .o_stored_index (o_stored_index),
        .o_status       (o_status)
    );

    // Stored nodes fill the row from the front without gaps
    for (genvar k = 1; k < ckhm_pkg::NODE_CAPACITY; k++) begin : g_chk
        a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            w_node_valid[k] |-> w_node_valid[k-1])
            else $error("gap in node store");
    end

    // A found key always reports ok status
    a_found_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_status == ckhm_pkg::ST_OK))
        else $error("found result with error status");

endmodule

FILE: hw/rtl/ckhm_cell.sv
module ckhm_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  ckhm_pkg::t_item i_item,
    output ckhm_pkg::t_item o_item,
    output logic           o_node_valid
);

    // Stored node
    logic                          r_node_valid;
    logic [ckhm_pkg::KEY_W-1:0]    r_key;
    logic [ckhm_pkg::PIDX_W-1:0]   r_pidx;

    // Stage register toward the next cell
    ckhm_pkg::t_item r_item;
    ckhm_pkg::t_item n_item;

    logic avail;
    logic match;
    logic claim;

    // Item still searching: compare against this node, or take it if free and the item is an insert
    assign avail = i_item.valid && !i_item.hit && !i_item.claimed;
    assign match = avail && r_node_valid && (r_key == i_item.key);
    assign claim = avail && !r_node_valid && (i_item.op == ckhm_pkg::OP_INSERT);

    always_comb begin
        n_item = i_item;
        if (match) begin
            n_item.hit = 1'b1;
            n_item.idx = r_pidx;
        end
        if (claim) begin
            n_item.claimed = 1'b1;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_valid <= 1'b0;
            r_item.valid <= 1'b0;
        end else if (i_adv) begin
            r_item <= n_item;
            if (claim) begin
                r_node_valid <= 1'b1;
            end
        end
    end

    // Node payload, written once when claimed
    always_ff @(posedge i_clk) begin
        if (i_adv && claim) begin
            r_key  <= i_item.key;
            r_pidx <= i_item.pidx;
        end
    end

    assign o_item       = r_item;
    assign o_node_valid = r_node_valid;

    // A node once stored stays stored
    a_node_keep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_node_valid |=> r_node_valid)
        else $error("stored node lost");

    // The chain holds still while stalled
    a_stage_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_adv && r_item.valid) |=> ($stable(r_item) && $stable(r_node_valid)))
        else $error("stage moved during stall");

endmodule

FILE: hw/rtl/ckhm_out.sv
module ckhm_out (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  ckhm_pkg::t_item               i_item,
    output logic                          o_valid,
    output logic                          o_found,
    output logic [ckhm_pkg::PIDX_W-1:0]   o_stored_index,
    output logic [ckhm_pkg::STATUS_W-1:0] o_status
);

    logic                          r_valid;
    logic                          r_found;
    logic [ckhm_pkg::PIDX_W-1:0]   r_index;
    logic [ckhm_pkg::STATUS_W-1:0] r_status;

    logic                          n_found;
    logic [ckhm_pkg::PIDX_W-1:0]   n_index;
    logic [ckhm_pkg::STATUS_W-1:0] n_status;

    // Result encoding at the end of the chain
    always_comb begin
        n_found  = 1'b0;
        n_index  = '0;
        n_status = ckhm_pkg::ST_OK;
        if (i_item.op == ckhm_pkg::OP_LOOKUP) begin
            if (i_item.hit) begin
                n_found = 1'b1;
                n_index = i_item.idx;
            end
        end else if (i_item.hit) begin
            n_status = ckhm_pkg::ST_DUP;
        end else if (!i_item.claimed) begin
            n_status = ckhm_pkg::ST_FULL;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_item.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_found  <= n_found;
            r_index  <= n_index;
            r_status <= n_status;
        end
    end

    assign o_valid        = r_valid;
    assign o_found        = r_found;
    assign o_stored_index = r_index;
    assign o_status       = r_status;

endmodule
